/* rtl/sspk_pkg.sv */
`timescale 1ns / 1ps

package sspk_pkg;

  // Fixed field widths
  localparam int CMD_W      = 2;
  localparam int LEVEL_W    = 7;
  localparam int BAND_W     = 6;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int CNT_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [CNT_W-1:0]   CNT_MAX        = '1;
  localparam logic [LEVEL_W-1:0] PEAK_DROP_INIT = 7'd6;

  // Command codes of an input word
  localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CHAN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_NONE   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_STORED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD    = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SNR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_DROP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_INDEX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEMOD_MODE = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // latch the input word
    logic scan_start;  // reset the slot walk
    logic scan_step;   // read one slot
    logic apply;       // update state, load the result register
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scan;   // latched word needs a walk over the slots
    logic scan_last;   // walk address is at the last slot
    logic out_busy;    // result register holds a word that is stalled
  } ctl_stat_t;

endpackage

/* rtl/station_scan_peak_store.sv */
`timescale 1ns / 1ps

// Channel  | Signals                                        | Direction
// ---------+------------------------------------------------+----------
// item     | item_valid, item_stall; cmd, replace,          | in
//          | chan_freq, level, snr                          |
// result   | result_valid, result_stall; status,            | out
//          | station_freq, slot_used, stored_total          |
// cfg      | cfg_valid, cfg_ready; cfg_index, cfg_data      | in
//
// Flow: one word at a time. A word that touches no slot (bad mode, plain
//   start, channel that only moves the peak, idle finish) goes from accept
//   via decide and apply. A commit or a start with replace walks the station
//   memory one slot a cycle through its single read port; drain and apply follow.
// Reset: rst is synchronous; slot occupancy sits in flops, so every slot is
//   free right after reset with no clearing pass. item_stall is high for the
//   reset cycles and the first cycle after.
// Stalls: the result register holds a word until taken; a finished word
//   waits in apply while the held word is stalled. cfg_ready is always high;
//   registers must be written only while idle; the block does not enforce it.

module station_scan_peak_store #(
  parameter int SLOT_COUNT = 32,
  parameter int FREQ_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sspk_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sspk_pkg::CFG_DATA_W-1:0]        cfg_data,
  // input word
  input  logic                                   item_valid,
  output logic                                   item_stall,
  input  logic [sspk_pkg::CMD_W-1:0]             cmd,
  input  logic                                   replace,
  input  logic [FREQ_BITS-1:0]                   chan_freq,
  input  logic [sspk_pkg::LEVEL_W-1:0]           level,
  input  logic [sspk_pkg::LEVEL_W-1:0]           snr,
  // result word
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic [sspk_pkg::STATUS_W-1:0]          status,
  output logic [FREQ_BITS-1:0]                   station_freq,
  output logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] slot_used,
  output logic [sspk_pkg::CNT_W-1:0]             stored_total
);
  import sspk_pkg::*;

  ctl_cmd_t  ctl;
  ctl_stat_t stat;

  // writes must land only while idle (the block does not enforce it); the port never pushes back
  assign cfg_ready = 1'b1;

  // sequencer: accept, decide, slot walk, drain, apply
  sspk_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .ctl        (ctl)
  );

  // registers, peak tracker, station memory and result register
  sspk_datapath #(
    .SLOT_COUNT (SLOT_COUNT),
    .FREQ_BITS  (FREQ_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .replace      (replace),
    .chan_freq    (chan_freq),
    .level        (level),
    .snr          (snr),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .station_freq (station_freq),
    .slot_used    (slot_used),
    .stored_total (stored_total),
    .ctl          (ctl),
    .stat         (stat)
  );

endmodule

/* rtl/sspk_ctrl.sv */
`timescale 1ns / 1ps

module sspk_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  sspk_pkg::ctl_stat_t stat,
  output sspk_pkg::ctl_cmd_t  ctl
);
  import sspk_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_DRAIN,
    S_APPLY
  } state_t;

  state_t state;

  always_comb begin
    ctl            = '0;
    ctl.capture    = (state == S_IDLE) && item_valid && !item_stall;
    ctl.scan_start = (state == S_DECIDE) && stat.need_scan;
    ctl.scan_step  = (state == S_SCAN);
    ctl.apply      = (state == S_APPLY) && !stat.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      item_stall <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid && !item_stall) begin
            state      <= S_DECIDE;
            item_stall <= 1'b1;
          end else begin
            item_stall <= 1'b0;
          end
        end
        S_DECIDE: begin
          state <= stat.need_scan ? S_SCAN : S_APPLY;
        end
        S_SCAN: begin
          if (stat.scan_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (!stat.out_busy) begin
            state      <= S_IDLE;
            item_stall <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_scan_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> ($past(state) == S_DECIDE || $past(state) == S_SCAN))
    else $error("slot walk entered without decision");

  a_drain_after_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> $past(stat.scan_last))
    else $error("drain before last slot read");

  a_stall_when_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> item_stall)
    else $error("input open while a word is in flight");

endmodule

/* rtl/sspk_datapath.sv */
`timescale 1ns / 1ps

module sspk_datapath #(
  parameter int SLOT_COUNT = 32,
  parameter int FREQ_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  input  logic [sspk_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sspk_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic [sspk_pkg::CMD_W-1:0]             cmd,
  input  logic                                   replace,
  input  logic [FREQ_BITS-1:0]                   chan_freq,
  input  logic [sspk_pkg::LEVEL_W-1:0]           level,
  input  logic [sspk_pkg::LEVEL_W-1:0]           snr,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic [sspk_pkg::STATUS_W-1:0]          status,
  output logic [FREQ_BITS-1:0]                   station_freq,
  output logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] slot_used,
  output logic [sspk_pkg::CNT_W-1:0]             stored_total,
  input  sspk_pkg::ctl_cmd_t                     ctl,
  output sspk_pkg::ctl_stat_t                    stat
);
  import sspk_pkg::*;

  localparam int SLOT_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(SLOT_COUNT - 1);
  localparam int ENTRY_W = FREQ_BITS + BAND_W + MODE_W;

  // config
  logic [LEVEL_W-1:0] min_level, min_snr, peak_drop;
  logic [BAND_W-1:0]  band_index;
  logic [MODE_W-1:0]  demod_mode;

  // latched word
  logic [CMD_W-1:0]   it_cmd;
  logic               it_replace;
  logic [FREQ_BITS-1:0] it_freq;
  logic [LEVEL_W-1:0] it_level, it_snr;

  // sweep state
  logic               peak_valid;
  logic [FREQ_BITS-1:0] peak_freq;
  logic [LEVEL_W-1:0] peak_level;
  logic [CNT_W-1:0]   stored_count;
  logic               full_flag;

  // station memory; occupancy lives in flops so reset frees every slot at once
  logic [SLOT_COUNT-1:0] occ;
  logic [ENTRY_W-1:0]    slot_mem [SLOT_COUNT];
  logic [ENTRY_W-1:0]    rd_data;
  logic [SLOT_BITS-1:0]  rd_idx, scan_addr, free_idx;
  logic                  rd_live, dup_found, free_found;
  logic [FREQ_BITS-1:0]  rd_freq;
  logic [BAND_W-1:0]     rd_band;
  logic [MODE_W-1:0]     rd_mode;

  // decisions
  logic is_start, is_chan, is_fin, bad_mode;
  logic pass, take, chan_commit, do_commit;
  logic [LEVEL_W-1:0] drop;
  logic [STATUS_W-1:0] commit_status;
  logic [FREQ_BITS-1:0] commit_freq;
  logic commit_store;
  logic [CNT_W-1:0] cnt_inc;

  // next values
  logic [STATUS_W-1:0]  res_status;
  logic [FREQ_BITS-1:0] res_freq;
  logic [SLOT_BITS-1:0] res_slot;
  logic                 peak_valid_next;
  logic [FREQ_BITS-1:0] peak_freq_next;
  logic [LEVEL_W-1:0]   peak_level_next;
  logic [CNT_W-1:0]     stored_count_next;
  logic                 full_flag_next;
  logic                 store;

  assign rd_freq = rd_data[ENTRY_W-1 -: FREQ_BITS];
  assign rd_band = rd_data[MODE_W +: BAND_W];
  assign rd_mode = rd_data[MODE_W-1:0];

  assign is_start = (it_cmd == CMD_START);
  assign is_chan  = (it_cmd == CMD_CHAN);
  assign is_fin   = (it_cmd == CMD_FINISH);
  assign bad_mode = (it_cmd != CMD_NONE) && demod_mode[1];

  assign pass = (it_level >= min_level) && (it_snr >= min_snr);
  assign take = pass && (!peak_valid || (it_level > peak_level));
  assign drop = peak_level - it_level;
  assign chan_commit = pass ? (!take && (drop >= peak_drop)) : peak_valid;
  assign do_commit = !bad_mode && !full_flag
                     && ((is_chan && chan_commit) || (is_fin && peak_valid));

  assign stat.need_scan = !bad_mode && ((is_start && it_replace) || do_commit);
  assign stat.scan_last = (scan_addr == SLOT_LAST);
  assign stat.out_busy  = result_valid && result_stall;

  assign cnt_inc = (stored_count != CNT_MAX) ? stored_count + 1'b1 : stored_count;

  // outcome of a commit, from the finished slot walk
  always_comb begin
    commit_status = ST_STORED;
    commit_freq   = peak_freq;
    commit_store  = 1'b0;
    if (peak_freq == '0) begin
      // a zero frequency cannot be held and is reported as a duplicate
      commit_status = ST_DUP;
      commit_freq   = '0;
    end else if (dup_found) begin
      commit_status = ST_DUP;
    end else if (!free_found) begin
      commit_status = ST_FULL;
      commit_freq   = '0;
    end else begin
      commit_store  = 1'b1;
    end
  end

  always_comb begin
    res_status        = ST_NONE;
    res_freq          = '0;
    res_slot          = '0;
    peak_valid_next   = peak_valid;
    peak_freq_next    = peak_freq;
    peak_level_next   = peak_level;
    stored_count_next = stored_count;
    full_flag_next    = full_flag;
    store             = 1'b0;
    if (bad_mode) begin
      res_status = ST_BAD;
    end else if (is_start) begin
      peak_valid_next   = 1'b0;
      peak_freq_next    = '0;
      peak_level_next   = '0;
      stored_count_next = '0;
      full_flag_next    = 1'b0;
    end else if ((is_chan || is_fin) && full_flag) begin
      res_status = ST_FULL;
    end else if (do_commit) begin
      res_status = commit_status;
      res_freq   = commit_freq;
      if (commit_store) begin
        res_slot          = free_idx;
        stored_count_next = cnt_inc;
        store             = 1'b1;
      end
      if (commit_status == ST_FULL) begin
        full_flag_next = 1'b1;
      end
      // a passing channel that ended the run opens the next one, unless memory is full
      if (is_chan && pass && commit_status != ST_FULL) begin
        peak_valid_next = 1'b1;
        peak_freq_next  = it_freq;
        peak_level_next = it_level;
      end else begin
        peak_valid_next = 1'b0;
        peak_freq_next  = '0;
        peak_level_next = '0;
      end
    end else if (is_chan && take) begin
      peak_valid_next = 1'b1;
      peak_freq_next  = it_freq;
      peak_level_next = it_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_level    <= '0;
      min_snr      <= '0;
      peak_drop    <= PEAK_DROP_INIT;
      band_index   <= '0;
      demod_mode   <= '0;
      peak_valid   <= 1'b0;
      peak_freq    <= '0;
      peak_level   <= '0;
      stored_count <= '0;
      full_flag    <= 1'b0;
      occ          <= '0;
      scan_addr    <= '0;
      rd_live      <= 1'b0;
      dup_found    <= 1'b0;
      free_found   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MIN_LEVEL:  min_level  <= cfg_data[LEVEL_W-1:0];
          CFG_MIN_SNR:    min_snr    <= cfg_data[LEVEL_W-1:0];
          CFG_PEAK_DROP:  peak_drop  <= cfg_data[LEVEL_W-1:0];
          CFG_BAND_INDEX: band_index <= cfg_data[BAND_W-1:0];
          CFG_DEMOD_MODE: demod_mode <= cfg_data[MODE_W-1:0];
          default: ;
        endcase
      end

      if (ctl.scan_start) begin
        scan_addr  <= '0;
        dup_found  <= 1'b0;
        free_found <= 1'b0;
      end
      if (ctl.scan_step) begin
        scan_addr <= scan_addr + 1'b1;
      end
      rd_live <= ctl.scan_step;

      if (rd_live) begin
        if (is_start) begin
          if (rd_band == band_index) begin
            occ[rd_idx] <= 1'b0;
          end
        end else begin
          if (occ[rd_idx] && rd_freq == peak_freq && rd_mode == demod_mode) begin
            dup_found <= 1'b1;
          end
          if (!occ[rd_idx] && !free_found) begin
            free_found <= 1'b1;
          end
        end
      end

      if (ctl.apply) begin
        peak_valid   <= peak_valid_next;
        peak_freq    <= peak_freq_next;
        peak_level   <= peak_level_next;
        stored_count <= stored_count_next;
        full_flag    <= full_flag_next;
        if (store) begin
          occ[free_idx] <= 1'b1;
        end
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      it_cmd     <= cmd;
      it_replace <= replace;
      it_freq    <= chan_freq;
      it_level   <= level;
      it_snr     <= snr;
    end
    if (ctl.scan_step) begin
      rd_idx <= scan_addr;
    end
    if (rd_live && !is_start && !occ[rd_idx] && !free_found) begin
      free_idx <= rd_idx;
    end
    if (ctl.apply) begin
      status       <= res_status;
      station_freq <= res_freq;
      slot_used    <= res_slot;
      stored_total <= stored_count_next;
    end
  end

  // station memory
  always_ff @(posedge clk) begin
    if (ctl.apply && store) begin
      slot_mem[free_idx] <= {peak_freq, band_index, demod_mode};
    end
    if (ctl.scan_step) begin
      rd_data <= slot_mem[scan_addr];
    end
  end

  a_apply_out_free: assert property (@(posedge clk) disable iff (rst)
    ctl.apply |-> !(result_valid && result_stall))
    else $error("result register overwritten while stalled");

  a_result_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(ctl.apply))
    else $error("result word without apply");

  a_store_marks_slot: assert property (@(posedge clk) disable iff (rst)
    (ctl.apply && store) |=> occ[free_idx])
    else $error("stored slot not marked occupied");

endmodule

/* sim/station_scan_peak_store_check.sv */
`timescale 1ns / 1ps

module station_scan_peak_store_check (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [sspk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sspk_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            item_valid,
  input  logic                            item_stall,
  input  logic [sspk_pkg::CMD_W-1:0]      cmd,
  input  logic                            replace,
  input  logic [15:0]                     chan_freq,
  input  logic [sspk_pkg::LEVEL_W-1:0]    level,
  input  logic [sspk_pkg::LEVEL_W-1:0]    snr,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  logic [sspk_pkg::STATUS_W-1:0]   status,
  input  logic [15:0]                     station_freq,
  input  logic [4:0]                      slot_used,
  input  logic [sspk_pkg::CNT_W-1:0]      stored_total,
  output int                              fail_count,
  output int                              open_words,
  output int                              words_checked,
  output int                              stored_seen,
  output int                              full_seen
);
  import sspk_pkg::*;

  localparam int SLOTS = 32;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [15:0]         station_freq;
    logic [4:0]          slot_used;
    logic [CNT_W-1:0]    stored_total;
  } scan_report_t;

  // station memory and sweep state
  logic [15:0]        mem_freq [SLOTS];
  logic [BAND_W-1:0]  mem_band [SLOTS];
  logic [MODE_W-1:0]  mem_mode [SLOTS];
  logic               pk_valid;
  logic [15:0]        pk_freq;
  logic [LEVEL_W-1:0] pk_level;
  logic [CNT_W-1:0]   count_since_start;
  logic               is_full;

  // register copies
  logic [LEVEL_W-1:0] thr_level, thr_snr, drop_step;
  logic [BAND_W-1:0]  band_now;
  logic [MODE_W-1:0]  mode_now;

  scan_report_t awaited_reports [$];
  int errs, checked, n_stored, n_full;

  function void clear_sweep_state();
    int i;
    for (i = 0; i < SLOTS; i++) begin
      mem_freq[i] = '0;
      mem_band[i] = '0;
      mem_mode[i] = '0;
    end
    pk_valid = 1'b0;
    pk_freq = '0;
    pk_level = '0;
    count_since_start = '0;
    is_full = 1'b0;
    thr_level = '0;
    thr_snr = '0;
    drop_step = PEAK_DROP_INIT;
    band_now = '0;
    mode_now = '0;
  endfunction

  // Try to put the held peak into the station memory.
  function void store_peak(output logic [STATUS_W-1:0] st, output logic [4:0] slot,
                           output logic [15:0] f);
    int i;
    int free_at;
    free_at = -1;
    slot = '0;
    f = '0;
    if (pk_freq == 16'd0) begin
      st = ST_DUP;
      return;
    end
    for (i = 0; i < SLOTS; i++)
      if (mem_freq[i] == pk_freq && mem_mode[i] == mode_now) begin
        f = pk_freq;
        st = ST_DUP;
        return;
      end
    for (i = 0; i < SLOTS; i++)
      if (free_at < 0 && mem_freq[i] == 16'd0) free_at = i;
    if (free_at < 0) begin
      is_full = 1'b1;
      st = ST_FULL;
      return;
    end
    mem_freq[free_at] = pk_freq;
    mem_band[free_at] = band_now;
    mem_mode[free_at] = mode_now;
    if (count_since_start != CNT_MAX) count_since_start = count_since_start + 1'b1;
    slot = 5'(free_at);
    f = pk_freq;
    st = ST_STORED;
  endfunction

  function scan_report_t advance_sweep(logic [CMD_W-1:0] c, logic rep, logic [15:0] f,
                                       logic [LEVEL_W-1:0] lv, logic [LEVEL_W-1:0] sn);
    scan_report_t r;
    logic pass, commit;
    int i;
    r = '0;
    commit = 1'b0;
    pass = (lv >= thr_level) && (sn >= thr_snr);
    if (c != CMD_NONE && mode_now >= 2) begin
      r.status = ST_BAD;
    end else begin
      case (c)
        CMD_START: begin
          if (rep)
            for (i = 0; i < SLOTS; i++)
              if (mem_band[i] == band_now) mem_freq[i] = '0;
          pk_valid = 1'b0;
          pk_freq = '0;
          pk_level = '0;
          count_since_start = '0;
          is_full = 1'b0;
        end
        CMD_CHAN: begin
          if (is_full) begin
            r.status = ST_FULL;
          end else begin
            if (pass) begin
              if (!pk_valid || lv > pk_level) begin
                pk_valid = 1'b1;
                pk_freq = f;
                pk_level = lv;
              end else if (int'(pk_level) - int'(lv) >= int'(drop_step)) begin
                commit = 1'b1;
              end
            end else if (pk_valid) begin
              commit = 1'b1;
            end
            if (commit) begin
              store_peak(r.status, r.slot_used, r.station_freq);
              // a full memory drops the peak; otherwise a passing channel restarts the run here
              pk_valid = (r.status != ST_FULL) && pass;
              pk_freq = pk_valid ? f : '0;
              pk_level = pk_valid ? lv : '0;
            end
          end
        end
        CMD_FINISH: begin
          if (is_full) begin
            r.status = ST_FULL;
          end else if (pk_valid) begin
            store_peak(r.status, r.slot_used, r.station_freq);
            pk_valid = 1'b0;
            pk_freq = '0;
            pk_level = '0;
          end
        end
        default: ;
      endcase
    end
    r.stored_total = count_since_start;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    scan_report_t want;
    if (rst) begin
      clear_sweep_state();
      awaited_reports.delete();
      errs = 0;
      checked = 0;
      n_stored = 0;
      n_full = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_LEVEL:  thr_level = cfg_data;
          CFG_MIN_SNR:    thr_snr = cfg_data;
          CFG_PEAK_DROP:  drop_step = cfg_data;
          CFG_BAND_INDEX: band_now = cfg_data[BAND_W-1:0];
          CFG_DEMOD_MODE: mode_now = cfg_data[MODE_W-1:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall)
        awaited_reports.push_back(advance_sweep(cmd, replace, chan_freq, level, snr));
      if (result_valid && !result_stall) begin
        checked++;
        if (status == ST_STORED) n_stored++;
        if (status == ST_FULL) n_full++;
        if (awaited_reports.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: stray result: st %0d f %h slot %0d tot %0d",
                     $realtime, status, station_freq, slot_used, stored_total);
        end else begin
          want = awaited_reports.pop_front();
          if (status !== want.status || station_freq !== want.station_freq ||
              slot_used !== want.slot_used || stored_total !== want.stored_total) begin
            errs++;
            if (errs <= 10)
              $display("%0t: word %0d exp st %0d f %h slot %0d tot %0d, %s",
                       $realtime, checked, want.status, want.station_freq,
                       want.slot_used, want.stored_total,
                       $sformatf("got st %0d f %h slot %0d tot %0d",
                                 status, station_freq, slot_used, stored_total));
          end
        end
      end
    end
    fail_count <= errs;
    open_words <= awaited_reports.size();
    words_checked <= checked;
    stored_seen <= n_stored;
    full_seen <= n_full;
  end

endmodule

/* sim/station_scan_peak_store_test.sv */
`timescale 1ns / 1ps

// Top of the station scan peak store bench: drives sweeps and settings, the
// checker beside the block does all prediction and comparison.
module station_scan_peak_store_test;
  import sspk_pkg::*;

  localparam int RUN_LIMIT = 600000;  // cycles
  localparam int DRAIN_CYCLES = 40;   // cycles to watch for stray results after the drain

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  item_valid;
  logic                  item_stall;
  logic [CMD_W-1:0]      cmd;
  logic                  replace;
  logic [15:0]           chan_freq;
  logic [LEVEL_W-1:0]    level;
  logic [LEVEL_W-1:0]    snr;
  logic                  result_valid;
  logic                  result_stall;
  logic [STATUS_W-1:0]   status;
  logic [15:0]           station_freq;
  logic [4:0]            slot_used;
  logic [CNT_W-1:0]      stored_total;

  int fail_count, open_words, words_checked, stored_seen, full_seen;

  // current idling, the settings last written to shape sweeps, and run counters
  int send_idle_pct = 0;
  int stall_pct = 0;
  int set_min_level = 0;
  int set_min_snr = 0;
  int words_sent = 0;
  int phases_run = 0;
  int cycle_count = 0;

  station_scan_peak_store dut (.*);

  station_scan_peak_store_check checker_i (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver side: stall at random at the phase's rate.
  always @(posedge clk)
    result_stall <= ($urandom_range(0, 99) < stall_pct);

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still open", cycle_count, open_words);
      $display("station_scan_peak_store verification failed");
      $finish;
    end
  end

  // One input word. Valid only drops when an idle gap is chosen, so a
  // back-to-back word never sees valid lowered and raised in one step.
  task automatic send_word(input logic [CMD_W-1:0] c, input logic rep, input logic [15:0] f,
                           input logic [LEVEL_W-1:0] lv, input logic [LEVEL_W-1:0] sn);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    item_valid <= 1'b1;
    cmd <= c;
    replace <= rep;
    chan_freq <= f;
    level <= lv;
    snr <= sn;
    do @(posedge clk); while (item_stall);
    words_sent++;
  endtask

  // Wait until every predicted result came back, plus a little slack so the
  // block has surely left its last word before registers change.
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (open_words != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_settings(input int ml, input int ms, input int pd, input int bi,
                                input int dm);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] val [5];
    int i;
    idx = '{CFG_MIN_LEVEL, CFG_MIN_SNR, CFG_PEAK_DROP, CFG_BAND_INDEX, CFG_DEMOD_MODE};
    val = '{7'(ml), 7'(ms), 7'(pd), 7'(bi), 7'(dm)};
    settle();
    for (i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    set_min_level = ml;
    set_min_snr = ms;
  endtask

  // Random part of a phase: mostly well-formed sweeps (start, a run of
  // channels with a wandering level, usually a finish), some raw noise words.
  task automatic run_sweeps(input int n_words);
    int sent, len, hill, step, i;
    logic [15:0] fr;
    logic [LEVEL_W-1:0] lv, sn;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 99) < 8) begin
        send_word(CMD_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 16'($urandom),
                  7'($urandom), 7'($urandom));
        sent++;
      end else begin
        // replace now and then so slots of this band get freed
        send_word(CMD_START, $urandom_range(0, 3) == 0, 16'($urandom), 7'($urandom),
                  7'($urandom));
        sent++;
        len = $urandom_range(3, 20);
        // a small pool of start frequencies makes repeated stations likely,
        // and includes frequency zero
        fr = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 15) * 64) : 16'($urandom);
        step = $urandom_range(1, 3);
        hill = $urandom_range(0, 40);
        for (i = 0; i < len; i++) begin
          hill = hill + int'($urandom_range(0, 50)) - 25;
          if (hill < 0) hill = 0;
          if (hill > 127) hill = 127;
          // map the hill onto the passing range of levels
          lv = 7'(set_min_level + (hill * (128 - set_min_level)) / 128);
          sn = 7'($urandom_range(set_min_snr, 127));
          if ($urandom_range(0, 99) < 15) begin
            if ($urandom_range(0, 1) == 1 && set_min_level > 0)
              lv = 7'($urandom_range(0, set_min_level - 1));
            else if (set_min_snr > 0)
              sn = 7'($urandom_range(0, set_min_snr - 1));
          end
          send_word(CMD_CHAN, 1'($urandom_range(0, 1)), fr, lv, sn);
          fr = fr + 16'(step);
          sent++;
        end
        if ($urandom_range(0, 99) < 85) begin
          send_word(CMD_FINISH, 1'($urandom_range(0, 1)), 16'($urandom), 7'($urandom),
                    7'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin : stimulus
    int p, n_words, band;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    item_valid <= 1'b0;
    cmd <= CMD_START;
    replace <= 1'b0;
    chan_freq <= '0;
    level <= '0;
    snr <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset settings: no thresholds, drop of 6, fm, band 0.
    send_word(CMD_FINISH, 1'b0, 16'h0000, 7'd0, 7'd0);      // finish with no peak
    send_word(CMD_NONE, 1'b1, 16'hFFFF, 7'h7F, 7'h7F);       // unused code
    send_word(CMD_START, 1'b1, 16'h0000, 7'd0, 7'd0);        // start, replace
    send_word(CMD_CHAN, 1'b0, 16'h0000, 7'd50, 7'd50);       // peak at frequency zero
    send_word(CMD_CHAN, 1'b0, 16'h0001, 7'd10, 7'd10);       // drop commits it: skipped
    send_word(CMD_CHAN, 1'b0, 16'hFFFF, 7'h7F, 7'h7F);       // new, strongest peak
    send_word(CMD_FINISH, 1'b0, 16'h0000, 7'd0, 7'd0);       // stored at slot 0
    send_word(CMD_START, 1'b0, 16'hFFFF, 7'h7F, 7'h7F);
    send_word(CMD_CHAN, 1'b1, 16'hFFFF, 7'h7F, 7'h7F);
    send_word(CMD_FINISH, 1'b1, 16'h0000, 7'd0, 7'd0);       // same station again
    send_word(CMD_CHAN, 1'b0, 16'h1234, 7'd0, 7'd0);
    send_word(CMD_CHAN, 1'b0, 16'h1235, 7'd0, 7'd0);         // level tie, no commit
    send_word(CMD_FINISH, 1'b0, 16'h0000, 7'd0, 7'd0);
    // sideband modes refuse every command
    write_settings(0, 0, 6, 0, 2);
    send_word(CMD_START, 1'b1, 16'h0000, 7'd0, 7'd0);
    send_word(CMD_CHAN, 1'b0, 16'h0100, 7'd90, 7'd90);
    send_word(CMD_FINISH, 1'b0, 16'h0000, 7'd0, 7'd0);
    write_settings(0, 0, 6, 0, 3);
    send_word(CMD_CHAN, 1'b0, 16'h0100, 7'd90, 7'd90);
    // top thresholds: only 127/127 passes, a failing channel ends the run
    write_settings(127, 127, 6, 0, 0);
    send_word(CMD_START, 1'b0, 16'h0000, 7'd0, 7'd0);
    send_word(CMD_CHAN, 1'b0, 16'h0200, 7'h7F, 7'd126);
    send_word(CMD_CHAN, 1'b0, 16'h0201, 7'h7F, 7'h7F);
    send_word(CMD_CHAN, 1'b0, 16'h0202, 7'd126, 7'h7F);
    send_word(CMD_FINISH, 1'b0, 16'h0000, 7'd0, 7'd0);

    // Random phases. Idling rotates: none, sender idle, receiver stall, both.
    for (p = 0; p < 12; p++) begin
      n_words = 85;
      case (p)
        0: write_settings(0, 0, 0, 63, 1);          // zero drop: any tie ends a run
        1: write_settings(127, 127, 127, 0, 0);     // top thresholds and drop
        2: write_settings(20, 10, 6, 5, 0);
        3: begin
          write_settings(0, 0, 6, 5, 3);            // short sideband phase
          n_words = 20;
        end
        default: begin
          // a few bands reused so replace finds slots to free
          case ($urandom_range(0, 4))
            0: band = 0;
            1: band = 5;
            2: band = 17;
            3: band = 63;
            default: band = $urandom_range(0, 63);
          endcase
          write_settings($urandom_range(0, 50), $urandom_range(0, 40),
                         ($urandom_range(0, 9) == 0) ? 127 : $urandom_range(0, 20), band,
                         ($urandom_range(0, 9) == 0) ? $urandom_range(2, 3)
                                                     : $urandom_range(0, 1));
        end
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 32; stall_pct = 32; end
      endcase
      run_sweeps(n_words);
      phases_run++;
    end

    // Drain: everything predicted must come back, then watch a bit longer
    // for stray result words.
    settle();
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d words over %0d random setting phases plus directed cases",
             words_sent, phases_run);
    $display("checked %0d results: %0d stations stored, %0d memory full, %0d mismatches",
             words_checked, stored_seen, full_seen, fail_count);
    if (fail_count == 0)
      $display("station_scan_peak_store verification clean");
    else
      $display("station_scan_peak_store verification failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/sspk_pkg.sv
rtl/sspk_ctrl.sv
rtl/sspk_datapath.sv
rtl/station_scan_peak_store.sv
sim/station_scan_peak_store_check.sv
sim/station_scan_peak_store_test.sv
